[src/pcpt_pkg.sv]
// Shared constants, types and functions of the preamble correlator.
package pcpt_pkg;

  localparam int unsigned PreambleLenDef = 32;
  localparam int unsigned SampleW = 16;
  localparam int unsigned CoefW = 11;
  localparam int unsigned CoefIdxW = 5;
  localparam int unsigned EnergyW = 18;
  localparam int unsigned MetricW = 17;
  localparam int unsigned AngleW = 16;
  localparam int unsigned CountW = 8;
  localparam int unsigned ProdShift = 16;
  localparam int unsigned EnergyShift = 14;
  localparam int unsigned CordicIters = 14;
  localparam int unsigned CordicW = 40;
  localparam int unsigned ZW = 18;
  localparam logic [CountW-1:0] CountStart = 8'd2;
  localparam logic [EnergyW-1:0] EnergyMax = 18'h3FFFF;
  localparam logic signed [ZW-1:0] PiQ13 = 18'sd25736;

  localparam logic [1:0] OpSearch = 2'd0;
  localparam logic [1:0] OpTiming = 2'd1;
  localparam logic [1:0] OpLoad = 2'd2;

  // Arctangent step table, Q3.13 radians.
  function automatic logic signed [ZW-1:0] atan_step(input logic [3:0] i);
    logic signed [ZW-1:0] r;
    case (i)
      4'd0: r = 18'sd6434;
      4'd1: r = 18'sd3798;
      4'd2: r = 18'sd2007;
      4'd3: r = 18'sd1019;
      4'd4: r = 18'sd511;
      4'd5: r = 18'sd256;
      4'd6: r = 18'sd128;
      4'd7: r = 18'sd64;
      4'd8: r = 18'sd32;
      4'd9: r = 18'sd16;
      4'd10: r = 18'sd8;
      4'd11: r = 18'sd4;
      4'd12: r = 18'sd2;
      4'd13: r = 18'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Sample handed along the cell row.
  typedef struct packed {
    logic signed [SampleW-1:0] re;
    logic signed [SampleW-1:0] im;
  } cplx_t;

endpackage

[src/preamble_correlator_phase_timing_unit.sv]
// Top level of the preamble correlator with phase and timing detection.
//
// Input words (op, sample, coefficient) use valid/ready; one result word per
// search or timing sample leaves on a valid/ready output channel. Coefficient
// loads give no result; a load beyond the preamble length is dropped. A sample
// word shifts the cell row at accept, then the single multiply-accumulate unit
// walks the taps, one tap per cycle after a first memory read step. A squaring
// step and a decision step follow, then the CORDIC runs 14 iterations when an
// angle is needed. The block takes no new input word until it has finished
// with the previous sample.
// The output register holds the result word until it is taken; a new input
// word is accepted only when that register is free, so a stalled receiver
// simply holds off the sender. Reset clears the delay line, history, mode
// (search) and countdown and sets the energy threshold to its maximum.
// Coefficient storage is not cleared; every tap must be loaded before use.
module preamble_correlator_phase_timing_unit import pcpt_pkg::*; #(
  parameter int unsigned PREAMBLE_LEN = PreambleLenDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [EnergyW-1:0]         cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 op_i,
  input  logic signed [SampleW-1:0]  sample_re_i,
  input  logic signed [SampleW-1:0]  sample_im_i,
  input  logic [CoefIdxW-1:0]        coef_index_i,
  input  logic signed [CoefW-1:0]    coef_re_i,
  input  logic signed [CoefW-1:0]    coef_im_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       phase_found_o,
  output logic signed [AngleW-1:0]   phase_angle_o,
  output logic [EnergyW-1:0]         energy_o,
  output logic                       timing_found_o,
  output logic signed [AngleW-1:0]   sym_shift_o,
  output logic signed [MetricW-1:0]  timing_metric_o,
  output logic [CountW-1:0]          countdown_o,
  output logic                       search_mode_o
);

  localparam int unsigned TapW = (PREAMBLE_LEN > 1) ? $clog2(PREAMBLE_LEN) : 1;
  // each tap adds at most 1025 in magnitude; 20 bits cover 128 taps
  localparam int unsigned AccW = 20;
  localparam int unsigned SqW = 2 * AccW;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMac = 3'd1;
  localparam logic [2:0] StSq = 3'd2;
  localparam logic [2:0] StDec = 3'd3;
  localparam logic [2:0] StCordic = 3'd4;
  localparam logic [2:0] StOut = 3'd5;

  logic [2:0] st_q, st_d;
  logic [EnergyW-1:0] thr_q;

  // cfg register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) thr_q <= EnergyMax;
    else if (cfg_we_i) thr_q <= cfg_wdata_i;
  end

  logic in_acc, is_sample;
  assign in_ready_o = (st_q == StIdle) && !out_valid_o;
  assign in_acc = in_valid_i && in_ready_o;
  assign is_sample = (op_i == OpSearch) || (op_i == OpTiming);

  // cell row: cell 0 takes the new sample; cell k tap meets coefficient
  // PREAMBLE_LEN-1-k
  cplx_t chain [PREAMBLE_LEN+1];
  cplx_t taps [PREAMBLE_LEN];
  assign chain[0] = '{re: sample_re_i, im: sample_im_i};

  for (genvar g = 0; g < PREAMBLE_LEN; g++) begin : g_cell
    pcpt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(in_acc && is_sample),
      .data_i (chain[g]),
      .tap_o  (taps[g]),
      .data_o (chain[g+1])
    );
  end

  // coefficient memory, conjugate stored
  logic signed [CoefW-1:0] cre_mem [PREAMBLE_LEN];
  logic signed [CoefW:0]   cim_mem [PREAMBLE_LEN];
  logic signed [CoefW-1:0] cre_rd;
  logic signed [CoefW:0]   cim_rd;
  logic [TapW-1:0] k_q, k_d;

  always_ff @(posedge clk_i) begin
    if (in_acc && op_i == OpLoad && 32'(coef_index_i) < PREAMBLE_LEN) begin
      cre_mem[coef_index_i[TapW-1:0]] <= coef_re_i;
      cim_mem[coef_index_i[TapW-1:0]] <= -(CoefW+1)'(coef_im_i);
    end
    cre_rd <= cre_mem[k_d];
    cim_rd <= cim_mem[k_d];
  end

  // tap select register aligned with memory read
  cplx_t tap_q;
  always_ff @(posedge clk_i) begin
    tap_q <= taps[TapW'(PREAMBLE_LEN - 1) - k_d];
  end

  logic [1:0] op_q;
  logic signed [AccW-1:0] acc_re_q, acc_im_q, acc_re_d, acc_im_d;
  logic mac_first_q, mac_first_d;
  logic signed [SampleW+CoefW+1:0] pr, pi_;
  logic signed [SqW-1:0] sq_re_q, sq_im_q;
  logic signed [SqW-1:0] en_full;
  logic signed [MetricW-1:0] h_q [4];
  logic signed [MetricW-1:0] pick_sat;
  logic signed [AccW-1:0] pick, abs_re, abs_im;
  logic found_q, found_d;
  logic [EnergyW-1:0] en_q;
  logic search_q;
  logic [CountW-1:0] cnt_q;
  logic cord_start;
  logic signed [MetricW+1:0] cy, cx;
  logic cord_done;
  logic signed [AngleW-1:0] cord_ang;

  assign pr = (SampleW+CoefW+2)'(cre_rd) * tap_q.re - (SampleW+CoefW+2)'(cim_rd) * tap_q.im;
  assign pi_ = (SampleW+CoefW+2)'(cre_rd) * tap_q.im + (SampleW+CoefW+2)'(cim_rd) * tap_q.re;

  always_comb begin
    st_d = st_q; k_d = k_q; mac_first_d = mac_first_q;
    acc_re_d = acc_re_q; acc_im_d = acc_im_q;
    unique case (st_q)
      StIdle: begin
        if (in_acc && is_sample) begin
          st_d = StMac; k_d = '0; mac_first_d = 1'b1;
          acc_re_d = '0; acc_im_d = '0;
        end
      end
      StMac: begin
        // first cycle waits for memory/tap read of index 0
        if (mac_first_q) begin
          mac_first_d = 1'b0;
        end else begin
          acc_re_d = acc_re_q + AccW'(pr >>> ProdShift);
          acc_im_d = acc_im_q + AccW'(pi_ >>> ProdShift);
          if (32'(k_q) == PREAMBLE_LEN - 1) begin
            st_d = StSq;
          end else begin
            k_d = k_q + TapW'(1);
          end
        end
      end
      StSq: st_d = StDec;
      StDec: st_d = cord_start ? StCordic : StOut;
      StCordic: if (cord_done) st_d = StOut;
      StOut: st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; k_q <= '0; mac_first_q <= 1'b0;
    end else begin
      st_q <= st_d; k_q <= k_d; mac_first_q <= mac_first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_re_q <= acc_re_d;
    acc_im_q <= acc_im_d;
    if (in_acc) op_q <= op_i;
    sq_re_q <= acc_re_q * acc_re_q;
    sq_im_q <= acc_im_q * acc_im_q;
  end

  assign en_full = (sq_re_q >>> EnergyShift) + (sq_im_q >>> EnergyShift);
  assign abs_re = (acc_re_q < 0) ? -acc_re_q : acc_re_q;
  assign abs_im = (acc_im_q < 0) ? -acc_im_q : acc_im_q;
  assign pick = (abs_re > abs_im) ? acc_re_q : acc_im_q;
  assign pick_sat = (pick > 32'sd65535) ? 17'sd65535 :
                    (pick < -32'sd65536) ? -17'sd65536 : pick[MetricW-1:0];

  // decision step: history, mode, countdown
  logic peak_ok;
  assign peak_ok = !(pick_sat > h_q[0] || pick_sat > h_q[1] ||
                     h_q[2] > h_q[0] || h_q[2] > h_q[1]);
  assign found_d = (op_q == OpSearch) ? (en_full > SqW'(thr_q)) : peak_ok;
  assign cord_start = (st_q == StDec) && found_d;
  assign cy = (op_q == OpSearch) ? (MetricW+2)'(acc_im_q) :
              (MetricW+2)'(h_q[2]) - (MetricW+2)'(h_q[0]);
  assign cx = (op_q == OpSearch) ? (MetricW+2)'(acc_re_q) :
              (MetricW+2)'(h_q[1]) - (MetricW+2)'(pick_sat);

  // CORDIC search inputs are bounded well inside 19 bits
  pcpt_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cord_start),
    .y_i    (cy),
    .x_i    (cx),
    .done_o (cord_done),
    .angle_o(cord_ang)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q[0] <= '0; h_q[1] <= '0; h_q[2] <= '0; h_q[3] <= '0;
      search_q <= 1'b1; cnt_q <= '0; found_q <= 1'b0; en_q <= '0;
    end else if (st_q == StDec) begin
      h_q[0] <= pick_sat; h_q[1] <= h_q[0]; h_q[2] <= h_q[1]; h_q[3] <= h_q[2];
      found_q <= found_d;
      if (op_q == OpSearch) begin
        search_q <= !found_d;
        if (found_d) cnt_q <= CountStart;
        en_q <= (en_full > SqW'(EnergyMax)) ? EnergyMax : en_full[EnergyW-1:0];
      end else begin
        cnt_q <= cnt_q - CountW'(1);
        en_q <= '0;
      end
    end
  end

  // output register
  logic ov_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (st_q == StOut) ov_q <= 1'b1;
    else if (out_ready_i) ov_q <= 1'b0;
  end

  logic signed [AngleW-1:0] ang_q;
  always_ff @(posedge clk_i) begin
    if (st_q == StDec) ang_q <= '0;
    else if (cord_done) ang_q <= cord_ang;
  end

  assign out_valid_o = ov_q;
  assign phase_found_o = found_q && (op_q == OpSearch);
  assign phase_angle_o = phase_found_o ? ang_q : '0;
  assign energy_o = en_q;
  assign timing_found_o = found_q && (op_q == OpTiming);
  assign sym_shift_o = timing_found_o ? ang_q : '0;
  assign timing_metric_o = h_q[0];
  assign countdown_o = cnt_q;
  assign search_mode_o = search_q;

  // checks
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != StIdle) |-> !in_ready_o) else $error("accept while busy");
  a_out_after_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(st_q == StOut)) else $error("stray result");
  a_mode_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StDec && op_q == OpSearch && found_d) |=> (cnt_q == CountStart && !search_q))
    else $error("mode update");

endmodule

[src/pcpt_cell.sv]
// One delay-line cell: holds two samples and shifts to its neighbor.
module pcpt_cell import pcpt_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  shift_i,
  input  cplx_t data_i,
  output cplx_t tap_o,
  output cplx_t data_o
);

  cplx_t even_q, odd_q;

  // Two line positions per cell; the older one is the correlation tap.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      even_q <= '0;
      odd_q <= '0;
    end else if (shift_i) begin
      even_q <= data_i;
      odd_q <= even_q;
    end
  end

  assign tap_o = odd_q;
  assign data_o = odd_q;

endmodule

[src/pcpt_cordic.sv]
// Iterative vectoring CORDIC for atan2, one micro-rotation per cycle.
module pcpt_cordic import pcpt_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [MetricW+1:0] y_i,
  input  logic signed [MetricW+1:0] x_i,
  output logic                     done_o,
  output logic signed [AngleW-1:0] angle_o
);

  logic signed [CordicW-1:0] x_q, x_d, y_q, y_d;
  logic signed [ZW-1:0] z_q, z_d;
  logic [3:0] it_q, it_d;
  logic busy_q, busy_d, done_q, done_d;
  logic signed [CordicW-1:0] xs, ys;
  logic zero_in;

  assign zero_in = (x_i == '0) && (y_i == '0);

  always_comb begin
    x_d = x_q; y_d = y_q; z_d = z_q; it_d = it_q;
    busy_d = busy_q; done_d = 1'b0;
    xs = x_q >>> it_q;
    ys = y_q >>> it_q;
    if (start_i) begin
      // pre-rotate into the right half plane
      x_d = CordicW'(x_i) <<< ProdShift;
      y_d = CordicW'(y_i) <<< ProdShift;
      z_d = '0;
      if (x_i < 0) begin
        x_d = -(CordicW'(x_i) <<< ProdShift);
        y_d = -(CordicW'(y_i) <<< ProdShift);
        z_d = (y_i >= 0) ? PiQ13 : -PiQ13;
      end
      it_d = '0;
      if (zero_in) begin
        z_d = '0;
        done_d = 1'b1;
      end else begin
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      if (y_q >= 0) begin
        x_d = x_q + ys; y_d = y_q - xs; z_d = z_q + atan_step(it_q);
      end else begin
        x_d = x_q - ys; y_d = y_q + xs; z_d = z_q - atan_step(it_q);
      end
      it_d = it_q + 4'd1;
      if (it_q == 4'(CordicIters - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      it_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      it_q <= it_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign done_o = done_q;
  assign angle_o = z_q[AngleW-1:0];

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for the preamble correlator phase/timing unit.
`timescale 1ns / 1ps

module tb;
  import pcpt_pkg::*;

  localparam int unsigned NTaps = PreambleLenDef;
  localparam int unsigned DrainCycles = 120;
  localparam logic [1:0] OpUnused = 2'd3;

  typedef struct {
    logic [1:0] op;
    logic signed [SampleW-1:0] s_re;
    logic signed [SampleW-1:0] s_im;
    logic [CoefIdxW-1:0] c_idx;
    logic signed [CoefW-1:0] c_re;
    logic signed [CoefW-1:0] c_im;
  } in_word_t;

  typedef struct {
    logic phase_found;
    logic signed [AngleW-1:0] phase_angle;
    logic [EnergyW-1:0] energy;
    logic timing_found;
    logic signed [AngleW-1:0] sym_shift;
    logic signed [MetricW-1:0] metric;
    logic [CountW-1:0] countdown;
    logic search_mode;
  } res_word_t;

  // Q3.13 vectoring arctangent, same iteration order as the block
  function automatic logic signed [AngleW-1:0] atan2_q13(longint y0, longint x0);
    longint x, y, z, dx, dy;
    if (x0 == 0 && y0 == 0) return '0;
    x = x0 * 65536;
    y = y0 * 65536;
    z = 0;
    if (x < 0) begin
      z = (y >= 0) ? 25736 : -25736;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CordicIters; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += longint'(atan_step(i[3:0]));
      end else begin
        x -= dx; y += dy; z -= longint'(atan_step(i[3:0]));
      end
    end
    return z[AngleW-1:0];
  endfunction

  // Correlator model plus queue of pending result words
  class corr_scoreboard;
    longint thresh;
    longint line_re[2*NTaps];
    longint line_im[2*NTaps];
    longint tap_re[NTaps];
    longint tap_im[NTaps];
    longint hist[4];
    bit searching;
    logic [CountW-1:0] steps;
    res_word_t pending[$];
    int errors;

    function void reset_state();
      thresh = EnergyMax;
      foreach (line_re[k]) begin line_re[k] = 0; line_im[k] = 0; end
      foreach (tap_re[k]) begin tap_re[k] = 0; tap_im[k] = 0; end
      foreach (hist[k]) hist[k] = 0;
      searching = 1;
      steps = '0;
      errors = 0;
    endfunction

    function void note_input(in_word_t w);
      longint cre, cim, ar, ai, sr, si, pick, en;
      res_word_t r;
      if (w.op == OpLoad) begin
        if (w.c_idx < NTaps) begin
          tap_re[w.c_idx] = w.c_re;
          tap_im[w.c_idx] = w.c_im;
        end
        return;
      end
      if (w.op != OpSearch && w.op != OpTiming) return;
      for (int k = 2*NTaps-1; k > 0; k--) begin
        line_re[k] = line_re[k-1];
        line_im[k] = line_im[k-1];
      end
      line_re[0] = w.s_re;
      line_im[0] = w.s_im;
      cre = 0;
      cim = 0;
      for (int k = 0; k < NTaps; k++) begin
        ar = tap_re[k];
        ai = -tap_im[k];
        sr = line_re[2*NTaps-1-2*k];
        si = line_im[2*NTaps-1-2*k];
        cre += (ar*sr - ai*si) >>> 16;
        cim += (ar*si + ai*sr) >>> 16;
      end
      pick = (((cre < 0) ? -cre : cre) > ((cim < 0) ? -cim : cim)) ? cre : cim;
      if (pick > 65535) pick = 65535;
      if (pick < -65536) pick = -65536;
      hist[3] = hist[2]; hist[2] = hist[1]; hist[1] = hist[0]; hist[0] = pick;
      r = '{default: '0};
      if (w.op == OpSearch) begin
        en = ((cre*cre) >>> 14) + ((cim*cim) >>> 14);
        searching = 1;
        if (en > thresh) begin
          r.phase_found = 1'b1;
          r.phase_angle = atan2_q13(cim, cre);
          searching = 0;
          steps = CountStart;
        end
        r.energy = (en > EnergyMax) ? EnergyMax : en[EnergyW-1:0];
      end else begin
        steps = steps - 1'b1;
        if (!(hist[0] > hist[1] || hist[0] > hist[2] || hist[3] > hist[1] ||
              hist[3] > hist[2])) begin
          r.timing_found = 1'b1;
          r.sym_shift = atan2_q13(hist[3] - hist[1], hist[2] - hist[0]);
        end
      end
      r.metric = hist[0][MetricW-1:0];
      r.countdown = steps;
      r.search_mode = searching;
      pending.insert(pending.size(), r);
    endfunction

    function void check_result(res_word_t a);
      res_word_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result word, nothing pending", $realtime);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.phase_found !== e.phase_found) begin
        $display("%0t: phase_found exp %0d got %0d", $realtime, e.phase_found,
                 a.phase_found); errors++;
      end
      if (a.phase_angle !== e.phase_angle) begin
        $display("%0t: phase_angle exp %0d got %0d", $realtime, e.phase_angle,
                 a.phase_angle); errors++;
      end
      if (a.energy !== e.energy) begin
        $display("%0t: energy exp %0d got %0d", $realtime, e.energy, a.energy);
        errors++;
      end
      if (a.timing_found !== e.timing_found) begin
        $display("%0t: timing_found exp %0d got %0d", $realtime, e.timing_found,
                 a.timing_found); errors++;
      end
      if (a.sym_shift !== e.sym_shift) begin
        $display("%0t: sym_shift exp %0d got %0d", $realtime, e.sym_shift,
                 a.sym_shift); errors++;
      end
      if (a.metric !== e.metric) begin
        $display("%0t: timing_metric exp %0d got %0d", $realtime, e.metric,
                 a.metric); errors++;
      end
      if (a.countdown !== e.countdown) begin
        $display("%0t: countdown exp %0d got %0d", $realtime, e.countdown,
                 a.countdown); errors++;
      end
      if (a.search_mode !== e.search_mode) begin
        $display("%0t: search_mode exp %0d got %0d", $realtime, e.search_mode,
                 a.search_mode); errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [EnergyW-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] op_i = OpSearch;
  logic signed [SampleW-1:0] sample_re_i = '0;
  logic signed [SampleW-1:0] sample_im_i = '0;
  logic [CoefIdxW-1:0] coef_index_i = '0;
  logic signed [CoefW-1:0] coef_re_i = '0;
  logic signed [CoefW-1:0] coef_im_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic phase_found_o;
  logic signed [AngleW-1:0] phase_angle_o;
  logic [EnergyW-1:0] energy_o;
  logic timing_found_o;
  logic signed [AngleW-1:0] sym_shift_o;
  logic signed [MetricW-1:0] timing_metric_o;
  logic [CountW-1:0] countdown_o;
  logic search_mode_o;

  corr_scoreboard sb;
  int burst_left;

  preamble_correlator_phase_timing_unit u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_ready_o,
    .op_i, .sample_re_i, .sample_im_i, .coef_index_i, .coef_re_i, .coef_im_i,
    .out_valid_o, .out_ready_i, .phase_found_o, .phase_angle_o, .energy_o,
    .timing_found_o, .sym_shift_o, .timing_metric_o, .countdown_o,
    .search_mode_o
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("tb: errors");
    $finish;
  end

  // Receiver: random stretches of always-ready, mostly-ready and mostly-stalled
  int stall_mode;
  always @(posedge clk_i) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= ($urandom_range(0, 3) != 0);
      default: out_ready_i <= ($urandom_range(0, 9) == 0);
    endcase
  end

  // Result monitor
  always @(posedge clk_i) begin
    res_word_t a;
    if (rst_ni && out_valid_o && out_ready_i) begin
      a.phase_found = phase_found_o;
      a.phase_angle = phase_angle_o;
      a.energy = energy_o;
      a.timing_found = timing_found_o;
      a.sym_shift = sym_shift_o;
      a.metric = timing_metric_o;
      a.countdown = countdown_o;
      a.search_mode = search_mode_o;
      sb.check_result(a);
    end
  end

  // Present one word and hold it until accepted; gaps come between bursts
  task automatic send_word(in_word_t w);
    int gap;
    in_valid_i <= 1'b1;
    op_i <= w.op;
    sample_re_i <= w.s_re;
    sample_im_i <= w.s_im;
    coef_index_i <= w.c_idx;
    coef_re_i <= w.c_re;
    coef_im_i <= w.c_im;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(w);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  function automatic in_word_t rand_word(logic [1:0] op);
    in_word_t w;
    w.op = op;
    w.s_re = SampleW'($urandom);
    w.s_im = SampleW'($urandom);
    w.c_idx = CoefIdxW'($urandom);
    w.c_re = CoefW'($urandom);
    w.c_im = CoefW'($urandom);
    return w;
  endfunction

  // Wait for the block to drain, then write the threshold
  task automatic set_threshold(logic [EnergyW-1:0] v);
    if (in_valid_i) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.thresh = v;
  endtask

  // One burst hunt: search samples, then a run of timing samples
  task automatic hunt_sequence();
    int n;
    n = $urandom_range(1, 6);
    repeat (n) send_word(rand_word(OpSearch));
    n = $urandom_range(2, 8);
    repeat (n) send_word(rand_word(OpTiming));
  endtask

  int roll;
  in_word_t w;
  logic [EnergyW-1:0] thr_set[6] = '{EnergyMax, 18'd0, 18'd60, 18'd250, 18'd1500,
                                     EnergyMax};

  initial begin
    sb = new();
    sb.reset_state();
    stall_mode = 0;
    burst_left = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Load every tap before any sample uses it
    for (int k = 0; k < NTaps; k++) begin
      w = rand_word(OpLoad);
      w.c_idx = CoefIdxW'(k);
      if (k == 0) begin w.c_re = -11'sd1024; w.c_im = 11'sd1023; end
      if (k == 1) begin w.c_re = 11'sd1023; w.c_im = -11'sd1024; end
      send_word(w);
    end

    // Directed: extreme samples, both sample ops, unused op, max index
    set_threshold(18'd0);
    w = rand_word(OpSearch); w.s_re = 16'sh7FFF; w.s_im = -16'sh8000; send_word(w);
    w = rand_word(OpSearch); w.s_re = -16'sh8000; w.s_im = 16'sh7FFF; send_word(w);
    w = rand_word(OpSearch); w.s_re = '0; w.s_im = '0; send_word(w);
    for (int k = 0; k < 4; k++) begin
      w = rand_word(OpTiming); w.s_re = 16'sh7FFF; w.s_im = 16'sh7FFF; send_word(w);
    end
    w = rand_word(OpTiming); w.s_re = -16'sh8000; w.s_im = -16'sh8000; send_word(w);
    send_word(rand_word(OpUnused));
    w = rand_word(OpLoad); w.c_idx = 5'd31; w.c_re = 11'sd1023; w.c_im = 11'sd1023;
    send_word(w);
    // timing steps long enough to wrap the countdown
    repeat (6) send_word(rand_word(OpTiming));
    send_word(rand_word(OpSearch));

    // Random phases across threshold settings
    foreach (thr_set[t]) begin
      set_threshold(thr_set[t]);
      for (int i = 0; i < 100; ) begin
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
          hunt_sequence();
          i += 8;
        end else if (roll < 88) begin
          send_word(rand_word(2'($urandom_range(0, 1))));
          i++;
        end else if (roll < 96) begin
          send_word(rand_word(OpLoad));
        end else begin
          send_word(rand_word(OpUnused));
        end
      end
    end

    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

[files.f]
src/pcpt_pkg.sv
src/pcpt_cell.sv
src/pcpt_cordic.sv
src/preamble_correlator_phase_timing_unit.sv
tb/sv/tb.sv
